>>> hdl/tic_pkg.sv
// shared types, codes and reset values of the turn indicator controller
package tic_pkg;

    localparam int unsigned COUNT_WIDTH_DEFAULT = 16;
    localparam int unsigned REG_WIDTH = 16;

    localparam logic [REG_WIDTH-1:0] HOLD_TICKS_RESET = 16'd950;
    localparam logic [REG_WIDTH-1:0] BLINK_TICKS_RESET = 16'd300;

    typedef enum logic [0:0] {
        REG_HOLD_TICKS = 1'b0,
        REG_BLINK_TICKS = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_OFF = 2'd0,
        MODE_LEFT = 2'd1,
        MODE_RIGHT = 2'd2,
        MODE_HAZARD = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        SAY_NONE = 2'd0,
        SAY_OFF = 2'd1,
        SAY_LEFT = 2'd2,
        SAY_RIGHT = 2'd3
    } say_t;

    typedef enum logic [1:0] {
        COMBO_NONE = 2'd0,
        COMBO_LEFT = 2'd1,
        COMBO_RIGHT = 2'd2,
        COMBO_BOTH = 2'd3
    } combo_t;

    typedef struct packed {
        logic left_pressed;
        logic right_pressed;
    } in_word_t;

    typedef struct packed {
        logic  left_lamp;
        logic  right_lamp;
        mode_t indicator_mode;
        say_t  announce;
    } out_word_t;

endpackage

>>> hdl/tic_in_if.sv
// input channel: one tick word with the two button levels
interface tic_in_if;
    logic valid;
    logic ready;
    logic left_pressed;
    logic right_pressed;

    modport source (output valid, output left_pressed, output right_pressed, input ready);
    modport sink (input valid, input left_pressed, input right_pressed, output ready);
endinterface

>>> hdl/tic_out_if.sv
// output channel: one result word with lamps, mode and announcement
interface tic_out_if;
    logic valid;
    logic ready;
    logic left_lamp;
    logic right_lamp;
    logic [1:0] indicator_mode;
    logic [1:0] announce;

    modport source (
        output valid, output left_lamp, output right_lamp,
        output indicator_mode, output announce, input ready
    );
    modport sink (
        input valid, input left_lamp, input right_lamp,
        input indicator_mode, input announce, output ready
    );
endinterface

>>> hdl/tic_core.sv
// indicator state: hold timing, release wait, mode changes and lamp blinking
module tic_core #(
    parameter int unsigned COUNT_WIDTH = tic_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [tic_pkg::REG_WIDTH-1:0]  hold_ticks,
    input  logic [tic_pkg::REG_WIDTH-1:0]  blink_ticks,
    input  tic_pkg::in_word_t              word,
    output tic_pkg::out_word_t             result
);

    localparam int unsigned CMP_WIDTH =
        (COUNT_WIDTH > tic_pkg::REG_WIDTH) ? COUNT_WIDTH : tic_pkg::REG_WIDTH;

    tic_pkg::mode_t         mode_reg, mode_next;
    logic [1:0]             held_combo_reg, held_combo_next;
    logic [COUNT_WIDTH-1:0] hold_count_reg, hold_count_next;
    logic [1:0]             release_wait_reg, release_wait_next;
    logic [COUNT_WIDTH-1:0] blink_count_reg, blink_count_next;
    logic                   left_lamp_reg, left_lamp_next;
    logic                   right_lamp_reg, right_lamp_next;

    logic [1:0]             combo;
    logic [1:0]             wait_cleared;
    logic [COUNT_WIDTH-1:0] hold_step;
    logic [COUNT_WIDTH-1:0] blink_inc;
    logic                   due;
    tic_pkg::say_t          say;

    assign combo = {word.right_pressed, word.left_pressed};

    always_comb
    begin
        mode_next = mode_reg;
        held_combo_next = held_combo_reg;
        hold_count_next = hold_count_reg;
        say = tic_pkg::SAY_NONE;
        hold_step = '0;

        // release wait
        wait_cleared = release_wait_reg;
        if ((release_wait_reg != 2'b00) && ((combo & release_wait_reg) == 2'b00))
        begin
            wait_cleared = 2'b00;
        end
        release_wait_next = wait_cleared;

        if (wait_cleared == 2'b00)
        begin
            if (combo == tic_pkg::COMBO_NONE)
            begin
                held_combo_next = 2'b00;
                hold_count_next = '0;
            end
            else
            begin
                if (combo != held_combo_reg)
                begin
                    hold_step = COUNT_WIDTH'(1);
                end
                else if (hold_count_reg == '1)
                begin
                    hold_step = hold_count_reg;
                end
                else
                begin
                    hold_step = hold_count_reg + 1'b1;
                end
                held_combo_next = combo;
                hold_count_next = hold_step;
                if (CMP_WIDTH'(hold_step) >= CMP_WIDTH'(hold_ticks))
                begin
                    case (combo)
                        tic_pkg::COMBO_BOTH:
                        begin
                            mode_next = tic_pkg::MODE_HAZARD;
                        end
                        tic_pkg::COMBO_LEFT:
                        begin
                            if ((mode_reg == tic_pkg::MODE_HAZARD) ||
                                (mode_reg == tic_pkg::MODE_LEFT))
                            begin
                                mode_next = tic_pkg::MODE_OFF;
                                say = tic_pkg::SAY_OFF;
                            end
                            else
                            begin
                                mode_next = tic_pkg::MODE_LEFT;
                                say = tic_pkg::SAY_LEFT;
                            end
                        end
                        default:
                        begin
                            if ((mode_reg == tic_pkg::MODE_HAZARD) ||
                                (mode_reg == tic_pkg::MODE_RIGHT))
                            begin
                                mode_next = tic_pkg::MODE_OFF;
                                say = tic_pkg::SAY_OFF;
                            end
                            else
                            begin
                                mode_next = tic_pkg::MODE_RIGHT;
                                say = tic_pkg::SAY_RIGHT;
                            end
                        end
                    endcase
                    release_wait_next = combo;
                    held_combo_next = 2'b00;
                    hold_count_next = '0;
                end
            end
        end

        // lamps
        blink_inc = (blink_count_reg == '1) ? blink_count_reg : blink_count_reg + 1'b1;
        due = (mode_next != tic_pkg::MODE_OFF) &&
              (CMP_WIDTH'(blink_inc) >= CMP_WIDTH'(blink_ticks));
        blink_count_next = due ? '0 : blink_inc;
        left_lamp_next = left_lamp_reg;
        right_lamp_next = right_lamp_reg;
        unique case (mode_next)
            tic_pkg::MODE_LEFT:
            begin
                right_lamp_next = 1'b0;
                left_lamp_next = left_lamp_reg ^ due;
            end
            tic_pkg::MODE_RIGHT:
            begin
                left_lamp_next = 1'b0;
                right_lamp_next = right_lamp_reg ^ due;
            end
            tic_pkg::MODE_HAZARD:
            begin
                left_lamp_next = left_lamp_reg ^ due;
                right_lamp_next = right_lamp_reg ^ due;
            end
            default:
            begin
                left_lamp_next = 1'b0;
                right_lamp_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tic_pkg::MODE_OFF;
            held_combo_reg <= 2'b00;
            hold_count_reg <= '0;
            release_wait_reg <= 2'b00;
            blink_count_reg <= '0;
            left_lamp_reg <= 1'b0;
            right_lamp_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            held_combo_reg <= held_combo_next;
            hold_count_reg <= hold_count_next;
            release_wait_reg <= release_wait_next;
            blink_count_reg <= blink_count_next;
            left_lamp_reg <= left_lamp_next;
            right_lamp_reg <= right_lamp_next;
        end
    end

    assign result.left_lamp = left_lamp_next;
    assign result.right_lamp = right_lamp_next;
    assign result.indicator_mode = mode_next;
    assign result.announce = say;

endmodule

>>> hdl/turn_indicator_controller_top.sv
// top level of the turn indicator controller: registers, handshake and core
// Each input word is one tick with the levels of the left and right buttons, and
// each tick gives exactly one result word with both lamp drives, the indicator
// mode after the tick and an announcement code. A word is taken into an input
// register, passes the combinational indicator logic and lands in a result
// register, so one word is accepted every clock cycle while the output side
// keeps taking results; result valid rises as the word lands in that register.
// hold_ticks (index 0) and blink_ticks (index 1) are written over the plain
// write port and reset to 950 and 300; the counters are COUNT_WIDTH bits wide
// and saturate.
module turn_indicator_controller_top #(
    parameter int unsigned COUNT_WIDTH = tic_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [tic_pkg::REG_WIDTH-1:0] cfg_data,
    tic_in_if.sink                        tick_in,
    tic_out_if.source                     result_out
);

    logic [tic_pkg::REG_WIDTH-1:0] hold_ticks_reg;
    logic [tic_pkg::REG_WIDTH-1:0] blink_ticks_reg;

    logic               in_valid_reg;
    tic_pkg::in_word_t  in_word_reg;
    logic               out_valid_reg;
    tic_pkg::out_word_t out_word_reg;
    tic_pkg::out_word_t result;
    logic               advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg <= tic_pkg::HOLD_TICKS_RESET;
            blink_ticks_reg <= tic_pkg::BLINK_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (tic_pkg::reg_index_t'(cfg_index))
                tic_pkg::REG_HOLD_TICKS: hold_ticks_reg <= cfg_data;
                tic_pkg::REG_BLINK_TICKS: blink_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign advance = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign tick_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick_in.ready)
            begin
                in_valid_reg <= tick_in.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_in.ready && tick_in.valid)
        begin
            in_word_reg.left_pressed <= tick_in.left_pressed;
            in_word_reg.right_pressed <= tick_in.right_pressed;
        end
        if (advance)
        begin
            out_word_reg <= result;
        end
    end

    tic_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .hold_ticks  (hold_ticks_reg),
        .blink_ticks (blink_ticks_reg),
        .word        (in_word_reg),
        .result      (result)
    );

    assign result_out.valid = out_valid_reg;
    assign result_out.left_lamp = out_word_reg.left_lamp;
    assign result_out.right_lamp = out_word_reg.right_lamp;
    assign result_out.indicator_mode = out_word_reg.indicator_mode;
    assign result_out.announce = out_word_reg.announce;

endmodule

>>> bench/turn_indicator_controller_top_test.sv
// self-checking bench for the turn indicator controller: button ticks in, lamp words checked
module turn_indicator_controller_top_test;

    localparam int CYCLE_LIMIT = 50000;
    localparam int MAX_PRINTED = 200;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = tic_pkg::REG_HOLD_TICKS;
    logic [tic_pkg::REG_WIDTH-1:0] cfg_data = '0;

    logic send_valid = 1'b0;
    tic_pkg::in_word_t send_word = '0;
    logic take_ready = 1'b0;

    tic_in_if tick_if ();
    tic_out_if result_if ();

    assign tick_if.valid = send_valid;
    assign tick_if.left_pressed = send_word.left_pressed;
    assign tick_if.right_pressed = send_word.right_pressed;
    assign result_if.ready = take_ready;

    turn_indicator_controller_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .tick_in    (tick_if),
        .result_out (result_if)
    );

    // predictor state
    logic [15:0] cfg_hold = tic_pkg::HOLD_TICKS_RESET;
    logic [15:0] cfg_blink = tic_pkg::BLINK_TICKS_RESET;
    tic_pkg::mode_t ind_mode = tic_pkg::MODE_OFF;
    tic_pkg::combo_t held = tic_pkg::COMBO_NONE;
    tic_pkg::combo_t wait_mask = tic_pkg::COMBO_NONE;
    logic [15:0] hold_cnt = '0;
    logic [15:0] blink_cnt = '0;
    logic lamp_l = 1'b0;
    logic lamp_r = 1'b0;

    tic_pkg::in_word_t tick_backlog[$];
    tic_pkg::out_word_t lamp_expect[$];

    int send_gap_pct = 0;
    int take_gap_pct = 0;
    int errors = 0;
    int results_seen = 0;
    int words_queued = 0;
    int cycle_count = 0;
    int stall_left = 0;
    logic stall_go = 1'b0;
    logic stall_done = 1'b0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic tic_pkg::out_word_t indicator_step(input logic lp, input logic rp);
        tic_pkg::combo_t c;
        tic_pkg::say_t say;
        logic due;
        tic_pkg::out_word_t w;
        c = tic_pkg::combo_t'({rp, lp});
        say = tic_pkg::SAY_NONE;
        if (wait_mask != tic_pkg::COMBO_NONE && (c & wait_mask) == tic_pkg::COMBO_NONE)
            wait_mask = tic_pkg::COMBO_NONE;
        if (wait_mask == tic_pkg::COMBO_NONE)
        begin
            if (c == tic_pkg::COMBO_NONE)
            begin
                held = tic_pkg::COMBO_NONE;
                hold_cnt = '0;
            end
            else
            begin
                if (c != held)
                begin
                    held = c;
                    hold_cnt = 16'd1;
                end
                else if (hold_cnt != '1)
                    hold_cnt = hold_cnt + 16'd1;
                if (hold_cnt >= cfg_hold)
                begin
                    case (c)
                        tic_pkg::COMBO_BOTH: ind_mode = tic_pkg::MODE_HAZARD;
                        tic_pkg::COMBO_LEFT:
                            if (ind_mode == tic_pkg::MODE_HAZARD ||
                                ind_mode == tic_pkg::MODE_LEFT)
                            begin
                                ind_mode = tic_pkg::MODE_OFF;
                                say = tic_pkg::SAY_OFF;
                            end
                            else
                            begin
                                ind_mode = tic_pkg::MODE_LEFT;
                                say = tic_pkg::SAY_LEFT;
                            end
                        default:
                            if (ind_mode == tic_pkg::MODE_HAZARD ||
                                ind_mode == tic_pkg::MODE_RIGHT)
                            begin
                                ind_mode = tic_pkg::MODE_OFF;
                                say = tic_pkg::SAY_OFF;
                            end
                            else
                            begin
                                ind_mode = tic_pkg::MODE_RIGHT;
                                say = tic_pkg::SAY_RIGHT;
                            end
                    endcase
                    wait_mask = c;
                    held = tic_pkg::COMBO_NONE;
                    hold_cnt = '0;
                end
            end
        end
        if (blink_cnt != '1)
            blink_cnt = blink_cnt + 16'd1;
        due = (ind_mode != tic_pkg::MODE_OFF) && (blink_cnt >= cfg_blink);
        if (due)
            blink_cnt = '0;
        case (ind_mode)
            tic_pkg::MODE_LEFT:
            begin
                lamp_r = 1'b0;
                if (due)
                    lamp_l = ~lamp_l;
            end
            tic_pkg::MODE_RIGHT:
            begin
                lamp_l = 1'b0;
                if (due)
                    lamp_r = ~lamp_r;
            end
            tic_pkg::MODE_HAZARD:
                if (due)
                begin
                    lamp_l = ~lamp_l;
                    lamp_r = ~lamp_r;
                end
            default:
            begin
                lamp_l = 1'b0;
                lamp_r = 1'b0;
            end
        endcase
        w.left_lamp = lamp_l;
        w.right_lamp = lamp_r;
        w.indicator_mode = ind_mode;
        w.announce = say;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got,
                     want);
    endtask

    task automatic queue_ticks(input tic_pkg::combo_t c, input int count);
        tic_pkg::in_word_t w;
        w.left_pressed = c[0];
        w.right_pressed = c[1];
        repeat (count)
            tick_backlog.push_back(w);
        words_queued += count;
    endtask

    task automatic wait_drained();
        while (tick_backlog.size() != 0 || send_valid || lamp_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input tic_pkg::reg_index_t idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == tic_pkg::REG_HOLD_TICKS)
            cfg_hold = value;
        else
            cfg_blink = value;
    endtask

    // press sequences around the hold time, cut-short presses and plain noise
    task automatic queue_button_play(input int count);
        int stop_at;
        int pick;
        int h;
        tic_pkg::combo_t c;
        stop_at = words_queued + count;
        h = (cfg_hold == 0) ? 1 : int'(cfg_hold);
        while (words_queued < stop_at)
        begin
            pick = $urandom_range(0, 99);
            c = tic_pkg::combo_t'($urandom_range(1, 3));
            if (pick < 70)
            begin
                queue_ticks(c, h + $urandom_range(0, 3));
                if ($urandom_range(0, 99) < 30)
                    queue_ticks(tic_pkg::combo_t'($urandom_range(1, 3)),
                                h + $urandom_range(0, 2));
                queue_ticks(tic_pkg::COMBO_NONE, $urandom_range(0, 6));
            end
            else if (pick < 85)
            begin
                if (h > 1)
                    queue_ticks(c, $urandom_range(1, h - 1));
                queue_ticks(tic_pkg::combo_t'($urandom_range(0, 3)), $urandom_range(1, 2));
            end
            else
                repeat ($urandom_range(1, 6))
                    queue_ticks(tic_pkg::combo_t'($urandom_range(0, 3)), 1);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_valid <= 1'b0;
            send_word <= '0;
        end
        else
        begin
            if (send_valid && tick_if.ready)
                lamp_expect.push_back(indicator_step(send_word.left_pressed,
                                                     send_word.right_pressed));
            if (!send_valid || tick_if.ready)
            begin
                if (tick_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    send_valid <= 1'b1;
                    send_word <= tick_backlog.pop_front();
                end
                else
                    send_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_left <= 0;
            stall_done <= 1'b0;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (stall_go && !stall_done)
        begin
            stall_left <= 300;
            stall_done <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        tic_pkg::out_word_t want;
        if (!rst_n)
            take_ready <= 1'b0;
        else
        begin
            if (result_if.valid && take_ready)
            begin
                if (lamp_expect.size() == 0)
                    report_mismatch("word with nothing expected", 0, 0);
                else
                begin
                    want = lamp_expect.pop_front();
                    if (result_if.left_lamp !== want.left_lamp)
                        report_mismatch("left_lamp", result_if.left_lamp, want.left_lamp);
                    if (result_if.right_lamp !== want.right_lamp)
                        report_mismatch("right_lamp", result_if.right_lamp, want.right_lamp);
                    if (result_if.indicator_mode !== want.indicator_mode)
                        report_mismatch("indicator_mode", result_if.indicator_mode,
                                        want.indicator_mode);
                    if (result_if.announce !== want.announce)
                        report_mismatch("announce", result_if.announce, want.announce);
                end
                results_seen++;
            end
            take_ready <= (stall_left == 0) && ($urandom_range(0, 99) >= take_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int seg;
        send_gap_pct = 12;
        take_gap_pct = 51;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: nothing acts yet
        queue_ticks(tic_pkg::COMBO_NONE, 1);
        queue_ticks(tic_pkg::COMBO_LEFT, 1);
        queue_ticks(tic_pkg::COMBO_BOTH, 1);
        wait_drained();

        // zero registers: act on the first held tick, toggle every tick
        write_reg(tic_pkg::REG_HOLD_TICKS, 16'd0);
        write_reg(tic_pkg::REG_BLINK_TICKS, 16'd0);
        queue_ticks(tic_pkg::COMBO_NONE, 1);
        queue_ticks(tic_pkg::COMBO_LEFT, 2);
        queue_ticks(tic_pkg::COMBO_BOTH, 1);
        queue_ticks(tic_pkg::COMBO_RIGHT, 1);
        queue_ticks(tic_pkg::COMBO_NONE, 1);
        queue_ticks(tic_pkg::COMBO_BOTH, 1);
        queue_ticks(tic_pkg::COMBO_LEFT, 1);
        queue_ticks(tic_pkg::COMBO_NONE, 1);
        queue_ticks(tic_pkg::COMBO_RIGHT, 1);
        queue_ticks(tic_pkg::COMBO_NONE, 1);
        queue_ticks(tic_pkg::COMBO_LEFT, 1);
        queue_ticks(tic_pkg::COMBO_NONE, 1);
        queue_ticks(tic_pkg::COMBO_LEFT, 1);
        queue_ticks(tic_pkg::COMBO_NONE, 1);
        queue_ticks(tic_pkg::COMBO_RIGHT, 1);
        queue_ticks(tic_pkg::COMBO_NONE, 1);
        queue_ticks(tic_pkg::COMBO_RIGHT, 1);
        queue_ticks(tic_pkg::COMBO_BOTH, 1);
        queue_ticks(tic_pkg::COMBO_NONE, 1);
        queue_ticks(tic_pkg::COMBO_LEFT, 1);
        wait_drained();

        for (seg = 0; seg < 6; seg++)
        begin
            send_gap_pct = (seg < 2) ? 12 : (seg < 4) ? 51 : 0;
            take_gap_pct = (seg < 2) ? 51 : (seg < 4) ? 12 : 0;
            case (seg)
                0:
                begin
                    write_reg(tic_pkg::REG_HOLD_TICKS, 16'd1);
                    write_reg(tic_pkg::REG_BLINK_TICKS, 16'd1);
                end
                1:
                begin
                    write_reg(tic_pkg::REG_HOLD_TICKS, 16'($urandom_range(2, 6)));
                    write_reg(tic_pkg::REG_BLINK_TICKS, 16'($urandom_range(2, 8)));
                end
                2:
                begin
                    write_reg(tic_pkg::REG_HOLD_TICKS, 16'($urandom_range(3, 10)));
                    write_reg(tic_pkg::REG_BLINK_TICKS, 16'($urandom_range(1, 20)));
                end
                3:
                begin
                    write_reg(tic_pkg::REG_HOLD_TICKS, 16'd4);
                    write_reg(tic_pkg::REG_BLINK_TICKS, 16'hFFFF);
                end
                4:
                begin
                    write_reg(tic_pkg::REG_HOLD_TICKS, 16'($urandom_range(1, 12)));
                    write_reg(tic_pkg::REG_BLINK_TICKS, 16'($urandom_range(1, 12)));
                end
                default:
                begin
                    write_reg(tic_pkg::REG_HOLD_TICKS, 16'd2);
                    write_reg(tic_pkg::REG_BLINK_TICKS, 16'd3);
                end
            endcase
            queue_button_play(275);
            if (seg == 2)
            begin
                @(posedge clk);
                stall_go <= 1'b1;
            end
            wait_drained();
        end

        // back to off, then a short off stretch
        if (ind_mode != tic_pkg::MODE_OFF)
        begin
            write_reg(tic_pkg::REG_HOLD_TICKS, 16'd1);
            queue_ticks(tic_pkg::COMBO_NONE, 1);
            queue_ticks(ind_mode == tic_pkg::MODE_RIGHT ? tic_pkg::COMBO_RIGHT
                                                        : tic_pkg::COMBO_LEFT, 1);
            queue_ticks(tic_pkg::COMBO_NONE, 1);
            wait_drained();
        end
        queue_ticks(tic_pkg::COMBO_NONE, 8);
        wait_drained();

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
hdl/tic_pkg.sv
hdl/tic_in_if.sv
hdl/tic_out_if.sv
hdl/tic_core.sv
hdl/turn_indicator_controller_top.sv
bench/turn_indicator_controller_top_test.sv
